/* rtl/xcrc_pkg.sv */
// Package with the shared types, codes and CRC function of the XMODEM-CRC receiver.
`timescale 1ns / 1ps

package xcrc_pkg;

    localparam int PAYLOAD_BYTES_DEF = 128;

    localparam logic [7:0] CH_SOH = 8'd1;
    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_ACK = 8'd6;
    localparam logic [7:0] CH_NAK = 8'd21;
    localparam logic [7:0] CH_C   = 8'd67;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_BYTE  = 1'b1;

    localparam logic [1:0] OUT_REPLY = 2'd0;
    localparam logic [1:0] OUT_WORD  = 2'd1;
    localparam logic [1:0] OUT_ABORT = 2'd2;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  reply_byte;
        logic [63:0] payload_word;
        logic        transfer_done;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SEQ,
        PH_SEQC,
        PH_DATA,
        PH_CRCH,
        PH_CRCL,
        PH_PREP,
        PH_WORD,
        PH_ACK
    } phase_t;

    typedef struct packed {
        logic       start;
        logic       ld_seq;
        logic       ld_seqc;
        logic       data_byte;
        logic       ld_crch;
        logic       rd_start;
        logic       rd_next;
        logic       seq_inc;
        logic       out_load;
        logic [1:0] out_kind;
        logic [7:0] out_reply;
        logic       out_word;
        logic       out_done;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic last_byte;
        logic pkt_ok;
        logic rd_last;
        logic out_free;
    } stat_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = {crc[7:0], crc[15:8]};
            c = c ^ {8'd0, b};
            c = c ^ {12'd0, c[7:4]};
            c = c ^ {c[3:0], 12'd0};
            c = c ^ {3'd0, c[7:0], 5'd0};
            crc_byte = c;
        end
    endfunction

endpackage

/* rtl/xcrc_ctrl.sv */
// Controller state machine of the XMODEM-CRC receiver.
`timescale 1ns / 1ps

module xcrc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  xcrc_pkg::item_t     item,
    input  xcrc_pkg::stat_t     stat,
    output xcrc_pkg::cmd_t      cmd
);

    xcrc_pkg::phase_t phase_reg;
    xcrc_pkg::phase_t phase_next;
    logic             accept;

    // Packet-end emission owns the output register, so no item is taken then.
    assign item_ready = !(phase_reg inside {xcrc_pkg::PH_PREP, xcrc_pkg::PH_WORD,
                                            xcrc_pkg::PH_ACK}) && stat.out_free;
    assign accept = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xcrc_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept && item.item_kind == xcrc_pkg::KIND_START)
        begin
            phase_next = xcrc_pkg::PH_HEADER;
        end
        else
        begin
            case (phase_reg)
                xcrc_pkg::PH_IDLE:
                begin
                    phase_next = xcrc_pkg::PH_IDLE;
                end
                xcrc_pkg::PH_HEADER:
                begin
                    if (accept)
                    begin
                        if (item.rx_byte == xcrc_pkg::CH_SOH)
                        begin
                            phase_next = xcrc_pkg::PH_SEQ;
                        end
                        else
                        begin
                            phase_next = xcrc_pkg::PH_IDLE;
                        end
                    end
                end
                xcrc_pkg::PH_SEQ:
                begin
                    if (accept)
                    begin
                        phase_next = xcrc_pkg::PH_SEQC;
                    end
                end
                xcrc_pkg::PH_SEQC:
                begin
                    if (accept)
                    begin
                        phase_next = xcrc_pkg::PH_DATA;
                    end
                end
                xcrc_pkg::PH_DATA:
                begin
                    if (accept && stat.last_byte)
                    begin
                        phase_next = xcrc_pkg::PH_CRCH;
                    end
                end
                xcrc_pkg::PH_CRCH:
                begin
                    if (accept)
                    begin
                        phase_next = xcrc_pkg::PH_CRCL;
                    end
                end
                xcrc_pkg::PH_CRCL:
                begin
                    if (accept)
                    begin
                        phase_next = stat.pkt_ok ? xcrc_pkg::PH_PREP : xcrc_pkg::PH_HEADER;
                    end
                end
                xcrc_pkg::PH_PREP:
                begin
                    phase_next = xcrc_pkg::PH_WORD;
                end
                xcrc_pkg::PH_WORD:
                begin
                    if (stat.out_free)
                    begin
                        phase_next = stat.rd_last ? xcrc_pkg::PH_ACK : xcrc_pkg::PH_PREP;
                    end
                end
                xcrc_pkg::PH_ACK:
                begin
                    if (stat.out_free)
                    begin
                        phase_next = xcrc_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = xcrc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        if (accept && item.item_kind == xcrc_pkg::KIND_START)
        begin
            cmd.start     = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_kind  = xcrc_pkg::OUT_REPLY;
            cmd.out_reply = xcrc_pkg::CH_C;
            cmd.out_last  = 1'b1;
        end
        else
        begin
            case (phase_reg)
                xcrc_pkg::PH_HEADER:
                begin
                    if (accept && item.rx_byte == xcrc_pkg::CH_EOT)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = xcrc_pkg::OUT_REPLY;
                        cmd.out_reply = xcrc_pkg::CH_ACK;
                        cmd.out_done  = 1'b1;
                        cmd.out_last  = 1'b1;
                    end
                    else if (accept && item.rx_byte != xcrc_pkg::CH_SOH)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = xcrc_pkg::OUT_ABORT;
                        cmd.out_last = 1'b1;
                    end
                end
                xcrc_pkg::PH_SEQ:
                begin
                    cmd.ld_seq = accept;
                end
                xcrc_pkg::PH_SEQC:
                begin
                    cmd.ld_seqc = accept;
                end
                xcrc_pkg::PH_DATA:
                begin
                    cmd.data_byte = accept;
                end
                xcrc_pkg::PH_CRCH:
                begin
                    cmd.ld_crch = accept;
                end
                xcrc_pkg::PH_CRCL:
                begin
                    if (accept && stat.pkt_ok)
                    begin
                        cmd.rd_start = 1'b1;
                    end
                    else if (accept)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = xcrc_pkg::OUT_REPLY;
                        cmd.out_reply = xcrc_pkg::CH_NAK;
                        cmd.out_last  = 1'b1;
                    end
                end
                xcrc_pkg::PH_WORD:
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = xcrc_pkg::OUT_WORD;
                        cmd.out_word = 1'b1;
                        cmd.rd_next  = 1'b1;
                    end
                end
                xcrc_pkg::PH_ACK:
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = xcrc_pkg::OUT_REPLY;
                        cmd.out_reply = xcrc_pkg::CH_ACK;
                        cmd.out_last  = 1'b1;
                        cmd.seq_inc   = 1'b1;
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

endmodule

/* rtl/xcrc_dp.sv */
// Datapath of the XMODEM-CRC receiver: header registers, CRC, payload memory, output register.
`timescale 1ns / 1ps

module xcrc_dp #(
    parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xcrc_pkg::item_t     item,
    input  xcrc_pkg::cmd_t      cmd,
    output xcrc_pkg::stat_t     stat,
    output logic                result_valid,
    input  logic                result_ready,
    output xcrc_pkg::result_t   result
);

    localparam int NWORDS = PAYLOAD_BYTES / 8;
    localparam int IW     = $clog2(PAYLOAD_BYTES);
    localparam int AW     = $clog2(NWORDS);

    logic [7:0]    expected_seq_reg;
    logic [7:0]    got_seq_reg;
    logic [7:0]    got_seqc_reg;
    logic [IW-1:0] byte_index_reg;
    logic [15:0]   crc_reg;
    logic [7:0]    crc_high_reg;
    logic [63:0]   asm_reg;
    logic [63:0]   asm_next;
    logic [AW-1:0] rd_addr_reg;
    logic [63:0]   rdata_reg;
    logic [63:0]   mem [NWORDS];
    logic          out_valid_reg;
    xcrc_pkg::result_t result_reg;
    logic [8:0]    seq_sum;

    // Each payload byte lands in its lane of the word being assembled.
    always_comb
    begin
        asm_next = asm_reg;
        asm_next[byte_index_reg[2:0]*8 +: 8] = item.rx_byte;
    end

    assign seq_sum = {1'b0, got_seq_reg} + {1'b0, got_seqc_reg};

    assign stat.last_byte = (byte_index_reg == IW'(PAYLOAD_BYTES - 1));
    assign stat.pkt_ok    = (seq_sum == 9'd255) && (got_seq_reg == expected_seq_reg)
                            && ({crc_high_reg, item.rx_byte} == crc_reg);
    assign stat.rd_last   = (rd_addr_reg == AW'(NWORDS - 1));
    assign stat.out_free  = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg <= 8'd1;
            got_seq_reg      <= 8'd0;
            got_seqc_reg     <= 8'd0;
            byte_index_reg   <= '0;
            crc_reg          <= 16'd0;
            crc_high_reg     <= 8'd0;
            rd_addr_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                expected_seq_reg <= 8'd1;
                got_seq_reg      <= 8'd0;
                got_seqc_reg     <= 8'd0;
                byte_index_reg   <= '0;
                crc_reg          <= 16'd0;
                crc_high_reg     <= 8'd0;
            end
            else if (cmd.seq_inc)
            begin
                expected_seq_reg <= expected_seq_reg + 8'd1;
            end
            if (cmd.ld_seq)
            begin
                got_seq_reg <= item.rx_byte;
            end
            if (cmd.ld_seqc)
            begin
                got_seqc_reg   <= item.rx_byte;
                byte_index_reg <= '0;
                crc_reg        <= 16'd0;
            end
            if (cmd.data_byte)
            begin
                crc_reg        <= xcrc_pkg::crc_byte(crc_reg, item.rx_byte);
                byte_index_reg <= stat.last_byte ? '0 : byte_index_reg + IW'(1);
            end
            if (cmd.ld_crch)
            begin
                crc_high_reg <= item.rx_byte;
            end
            if (cmd.rd_start)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_byte)
        begin
            asm_reg <= asm_next;
        end
        if (cmd.out_load)
        begin
            result_reg.out_kind      <= cmd.out_kind;
            result_reg.reply_byte    <= cmd.out_reply;
            result_reg.payload_word  <= cmd.out_word ? rdata_reg : 64'd0;
            result_reg.transfer_done <= cmd.out_done;
            result_reg.last          <= cmd.out_last;
        end
    end

    // Payload store: a full word is written when its eighth byte arrives.
    always_ff @(posedge clk)
    begin
        if (cmd.data_byte && byte_index_reg[2:0] == 3'd7)
        begin
            mem[byte_index_reg[IW-1:3]] <= asm_next;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/xmodem_crc_packet_receiver_core.sv */
// A reply or abort is offered in the cycle after the item that causes it is accepted.
// One byte is taken per cycle while the output register is free and no packet end is being
// emitted. A good packet then offers each payload word through a memory-read state (PREP)
// and an output-load state (WORD), then the ACK; a blocked output holds them, and no input is taken.
// Reset clears the state machine to idle and the sequence to 1; payload memory is not cleared.
// Top level of the XMODEM-CRC packet receiver.
`timescale 1ns / 1ps

module xmodem_crc_packet_receiver_core #(
    parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  xcrc_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_ready,
    output xcrc_pkg::result_t   result
);

    xcrc_pkg::cmd_t  cmd;
    xcrc_pkg::stat_t stat;

    xcrc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    xcrc_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!result_valid || result_ready))
        else $error("item taken while output register is blocked");

    a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_kind == xcrc_pkg::OUT_WORD) |-> !result.last)
        else $error("payload word marked as last result");

    a_done_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.transfer_done) |->
        (result.reply_byte == xcrc_pkg::CH_ACK && result.last))
        else $error("transfer done on a result other than the final ACK");

    a_start_replies: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.item_kind == xcrc_pkg::KIND_START) |=>
        (result_valid && result.reply_byte == xcrc_pkg::CH_C))
        else $error("start transaction did not produce the C reply");
`endif

endmodule
